@@ sv/bwc_pkg.sv @@
// ----------------------------------------------------------------------------
// bwc_pkg: shared types and constants of the box window correlator
// Payload structures, descriptor layout, box type codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package bwc_pkg;

	localparam int SAMPLE_BITS      = 12;
	localparam int DEF_MAX_BOXES    = 6;
	localparam int DEF_RING_DEPTH   = 1024;
	localparam int DESC_BITS        = 59;
	localparam int SUM_BITS         = SAMPLE_BITS + 10;
	localparam int SCORE_BITS       = 32;
	localparam int CFG_INDEX_BITS   = 3;

	// Register indexes on the configuration port.
	localparam logic [CFG_INDEX_BITS-1:0] CFG_NUM_BOXES  = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_DESC_FIRST = 3'd1;

	// Box type codes; the two unused codes behave as near.
	localparam logic [2:0] BT_NEAR    = 3'd0;
	localparam logic [2:0] BT_BELOW   = 3'd1;
	localparam logic [2:0] BT_ABOVE   = 3'd2;
	localparam logic [2:0] BT_SKIP    = 3'd3;
	localparam logic [2:0] BT_BETWEEN = 3'd4;
	localparam logic [2:0] BT_DUAL    = 3'd5;

	typedef struct packed {
		logic                   mode;
		logic [SAMPLE_BITS-1:0] sample;
		logic                   sample_valid;
	} in_item_t;

	typedef struct packed {
		logic signed [SCORE_BITS-1:0] score;
		logic                         score_valid;
	} out_item_t;

	typedef struct packed {
		logic signed [11:0]     threshold;
		logic [SAMPLE_BITS-1:0] expect2;
		logic [SAMPLE_BITS-1:0] expect1;
		logic [2:0]             btype;
		logic [9:0]             width;
		logic [9:0]             age;
	} desc_t;

	// Command handed from the front part to the back part.
	typedef struct packed {
		logic                   is_clear;
		logic [SAMPLE_BITS-1:0] sample;
		logic                   sample_valid;
	} cmd_t;

endpackage

`default_nettype wire

@@ sv/bwc_queue.sv @@
// ----------------------------------------------------------------------------
// bwc_queue: two-entry queue
// Small first-in first-out buffer with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module bwc_queue #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic                  empty,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/bwc_front.sv @@
// ----------------------------------------------------------------------------
// bwc_front: input side of the correlator
// Takes input transfers, sorts them into clear and feed commands and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module bwc_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bwc_pkg::in_item_t item,
	input  wire logic              push,
	output logic                   full,
	output bwc_pkg::cmd_t          cmd,
	output logic                   cmd_empty,
	input  wire logic              cmd_pop
);
	import bwc_pkg::*;

	cmd_t             cmd_in;
	logic [$bits(cmd_t)-1:0] cmd_bits;

	// A clear command carries no sample; its payload is forced to zero.
	always_comb begin
		cmd_in.is_clear     = item.mode;
		cmd_in.sample       = item.mode ? '0 : item.sample;
		cmd_in.sample_valid = !item.mode && item.sample_valid;
	end

	bwc_queue #(.WIDTH($bits(cmd_t))) u_cmd_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.wdata (cmd_in),
		.pop   (cmd_pop),
		.empty (cmd_empty),
		.rdata (cmd_bits)
	);

	assign cmd = cmd_t'(cmd_bits);

endmodule

`default_nettype wire

@@ sv/bwc_back.sv @@
// ----------------------------------------------------------------------------
// bwc_back: execution side of the correlator
// Sequencer holding the sample ring, box sums and fills, a bit-serial divider
// and the score accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module bwc_back #(
	parameter int MAX_BOXES  = bwc_pkg::DEF_MAX_BOXES,
	parameter int RING_DEPTH = bwc_pkg::DEF_RING_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [2:0]     num_boxes,
	input  wire bwc_pkg::desc_t desc [MAX_BOXES],
	input  wire bwc_pkg::cmd_t  cmd,
	input  wire logic           cmd_empty,
	output logic                cmd_pop,
	output bwc_pkg::out_item_t  res,
	output logic                res_push,
	input  wire logic           res_full
);
	import bwc_pkg::*;

	localparam int AW   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int DW   = ((AW > 11) ? AW : 11) + 1;
	localparam int SNW  = $clog2(RING_DEPTH + 1);
	localparam int CW   = (SNW > 11) ? SNW : 11;
	localparam int FLW  = $clog2(2 * RING_DEPTH);
	localparam int QW   = (FLW > 12) ? FLW : 12;
	localparam int BW   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int FW   = SUM_BITS + 2;
	localparam int RW   = SAMPLE_BITS + 1;
	localparam int CNTW = $clog2(SUM_BITS + 1);
	localparam logic [FLW-1:0] FILL_MAX = FLW'(2 * RING_DEPTH - 1);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_UPD_A = 4'd1;
	localparam logic [3:0] ST_UPD_B = 4'd2;
	localparam logic [3:0] ST_UPD_C = 4'd3;
	localparam logic [3:0] ST_QUAL  = 4'd4;
	localparam logic [3:0] ST_DIV   = 4'd5;
	localparam logic [3:0] ST_SCORE = 4'd6;
	localparam logic [3:0] ST_ACC   = 4'd7;
	localparam logic [3:0] ST_OUT   = 4'd8;

	function automatic logic signed [FW-1:0] neg_abs(input logic signed [FW-1:0] x);
		return (x > 0) ? -x : x;
	endfunction

	logic [3:0]              state_q;
	logic [RW-1:0]           ring [RING_DEPTH];
	logic [RW-1:0]           rd_q;
	logic [SUM_BITS-1:0]     sum_q  [MAX_BOXES];
	logic [FLW-1:0]          fill_q [MAX_BOXES];
	logic [SNW-1:0]          seen_q;
	logic [AW-1:0]           wp_q;
	logic [AW-1:0]           newest_q;
	logic [2:0]              box_q;
	logic [SUM_BITS-1:0]     div_q;
	logic [FLW-1:0]          rem_q;
	logic [CNTW-1:0]         cnt_q;
	logic signed [FW-1:0]    f_q;
	logic signed [SCORE_BITS-1:0] acc_q;
	logic [12:0]             tot_q;
	logic signed [15:0]      unc_q;
	out_item_t               res_q;

	logic [2:0]              nb;
	logic [BW-1:0]           bi;
	desc_t                   d;
	logic [10:0]             far_age;
	logic [AW-1:0]           addr_add;
	logic [AW-1:0]           addr_rem;
	logic [DW-1:0]           diff_add;
	logic [DW-1:0]           diff_rem;
	logic                    add_hit;
	logic                    rem_hit;
	logic [SUM_BITS:0]       sum_plus;
	logic [FLW:0]            rem_sh;
	logic                    rem_ge;
	logic [11:0]             w_min;
	logic signed [FW-1:0]    fq;
	logic signed [FW-1:0]    fx;
	logic signed [FW-1:0]    f2;
	logic signed [FW-1:0]    ex;
	logic signed [FW-1:0]    ex2;
	logic signed [FW-1:0]    th;
	logic signed [FW-1:0]    f_new;
	logic signed [FW+11:0]   prod;
	logic signed [19:0]      unc_x10;

	assign nb       = (num_boxes > 3'(MAX_BOXES)) ? 3'(MAX_BOXES) : num_boxes;
	assign bi       = box_q[BW-1:0];
	assign d        = desc[bi];
	assign far_age  = {1'b0, d.age} + {1'b0, d.width};
	assign diff_add = DW'(newest_q) - DW'(d.age);
	assign diff_rem = DW'(newest_q) - DW'(far_age);
	assign addr_add = diff_add[DW-1] ? AW'(diff_add + DW'(RING_DEPTH)) : diff_add[AW-1:0];
	assign addr_rem = diff_rem[DW-1] ? AW'(diff_rem + DW'(RING_DEPTH)) : diff_rem[AW-1:0];
	assign add_hit  = CW'(d.age) < CW'(seen_q);
	assign rem_hit  = CW'(far_age) < CW'(seen_q);
	assign sum_plus = {1'b0, sum_q[bi]} + (SUM_BITS+1)'(rd_q[SAMPLE_BITS-1:0]);
	assign rem_sh   = {rem_q, div_q[SUM_BITS-1]};
	assign rem_ge   = rem_sh >= {1'b0, fill_q[bi]};
	assign w_min    = 12'(({2'b0, d.width} * 12'd3) >> 2) + 12'd1;
	assign unc_x10  = 20'(unc_q) * 20'sd10;

	// Box score from the box average held in the divider register.
	always_comb begin
		fq    = $signed({2'b00, div_q});
		ex    = $signed(FW'(d.expect1));
		ex2   = $signed(FW'(d.expect2));
		th    = FW'(d.threshold);
		f2    = '0;
		fx    = '0;
		unique case (d.btype)
			BT_BELOW: begin
				fx    = ex - fq;
				f_new = ((fx <= 0) ? FW'(100) : fx) + th;
			end
			BT_ABOVE: begin
				fx    = fq - ex;
				f_new = ((fx <= 0) ? FW'(100) : fx) + th;
			end
			BT_SKIP: begin
				f_new = '0;
			end
			BT_BETWEEN, BT_DUAL: begin
				f2 = neg_abs(fq - ex2);
				fx = neg_abs(fq - ex);
				if (d.btype == BT_BETWEEN && fq > ex - th && fq < ex2 + th) begin
					f_new = FW'(100);
				end else begin
					f_new = ((f2 > fx) ? f2 : fx) + th;
				end
			end
			default: begin
				f_new = neg_abs(fq - ex) + th;
			end
		endcase
		if (f_new < 0) begin
			f_new = f_new <<< 2;
		end
	end

	assign prod = f_q * $signed({2'b00, d.width});

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && !cmd_empty && !cmd.is_clear) begin
			ring[wp_q] <= {cmd.sample_valid, cmd.sample};
		end
		rd_q <= ring[(state_q == ST_UPD_A) ? addr_add : addr_rem];
	end

	assign cmd_pop  = (state_q == ST_IDLE);
	assign res_push = (state_q == ST_OUT);
	assign res      = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			seen_q   <= '0;
			wp_q     <= '0;
			newest_q <= '0;
			box_q    <= '0;
			cnt_q    <= '0;
			div_q    <= '0;
			rem_q    <= '0;
			f_q      <= '0;
			acc_q    <= '0;
			tot_q    <= '0;
			unc_q    <= '0;
			res_q    <= '0;
			for (int k = 0; k < MAX_BOXES; k++) begin
				sum_q[k]  <= '0;
				fill_q[k] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!cmd_empty) begin
						if (cmd.is_clear) begin
							for (int k = 0; k < MAX_BOXES; k++) begin
								sum_q[k]  <= '0;
								fill_q[k] <= '0;
							end
							seen_q  <= '0;
							wp_q    <= '0;
							res_q   <= '0;
							state_q <= ST_OUT;
						end else begin
							newest_q <= wp_q;
							wp_q     <= (wp_q == AW'(RING_DEPTH - 1)) ? '0 : wp_q + AW'(1);
							if (seen_q < SNW'(RING_DEPTH)) begin
								seen_q <= seen_q + SNW'(1);
							end
							box_q   <= '0;
							state_q <= ST_UPD_A;
						end
					end
				end
				ST_UPD_A: begin
					if (box_q == nb) begin
						box_q   <= '0;
						acc_q   <= '0;
						tot_q   <= '0;
						unc_q   <= '0;
						state_q <= ST_QUAL;
					end else begin
						state_q <= ST_UPD_B;
					end
				end
				ST_UPD_B: begin
					// Ring data of the newest sample in the window is in rd_q.
					if (add_hit && rd_q[SAMPLE_BITS] && fill_q[bi] < FILL_MAX
					    && !sum_plus[SUM_BITS]) begin
						sum_q[bi]  <= sum_plus[SUM_BITS-1:0];
						fill_q[bi] <= fill_q[bi] + FLW'(1);
					end
					state_q <= ST_UPD_C;
				end
				ST_UPD_C: begin
					if (rem_hit && rd_q[SAMPLE_BITS]) begin
						if (fill_q[bi] == '0) begin
							sum_q[bi] <= '0;
						end else begin
							fill_q[bi] <= fill_q[bi] - FLW'(1);
							sum_q[bi]  <= (sum_q[bi] >= SUM_BITS'(rd_q[SAMPLE_BITS-1:0]))
							              ? sum_q[bi] - SUM_BITS'(rd_q[SAMPLE_BITS-1:0]) : '0;
						end
					end
					box_q   <= box_q + 3'd1;
					state_q <= ST_UPD_A;
				end
				ST_QUAL: begin
					if (box_q == nb) begin
						res_q.score_valid <= (unc_x10 <= $signed({7'b0, tot_q}));
						res_q.score       <= (unc_x10 <= $signed({7'b0, tot_q})) ? acc_q : '0;
						state_q           <= ST_OUT;
					end else if (QW'(fill_q[bi]) < QW'(w_min)) begin
						res_q   <= '0;
						state_q <= ST_OUT;
					end else begin
						div_q   <= sum_q[bi];
						rem_q   <= '0;
						cnt_q   <= CNTW'(SUM_BITS);
						tot_q   <= tot_q + 13'(d.width);
						unc_q   <= unc_q + 16'(d.width) - 16'(fill_q[bi]);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= rem_ge ? FLW'(rem_sh - {1'b0, fill_q[bi]}) : rem_sh[FLW-1:0];
					div_q <= {div_q[SUM_BITS-2:0], rem_ge};
					cnt_q <= cnt_q - CNTW'(1);
					if (cnt_q == CNTW'(1)) begin
						state_q <= ST_SCORE;
					end
				end
				ST_SCORE: begin
					f_q     <= f_new;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					acc_q   <= acc_q + prod[SCORE_BITS-1:0];
					box_q   <= box_q + 3'd1;
					state_q <= ST_QUAL;
				end
				ST_OUT: begin
					if (!res_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ sv/box_window_correlator.sv @@
// ----------------------------------------------------------------------------
// box_window_correlator: windowed box correlation of frequency samples
// Top level: configuration registers, command queue, sequencer, result queue.
// ----------------------------------------------------------------------------
// Each feed transfer stores one 12-bit sample in a ring of RING_DEPTH entries
// and updates the running sum and fill of every box in use, then scores the
// boxes in order and delivers one result transfer; a clear transfer empties
// all boxes and delivers a zero, invalid result. Each box in use needs two
// ring reads on the single ring port, and each qualifying box passes through
// the bit-serial divider that forms the box average one quotient bit per
// cycle. Scoring stops at the first box that is at most three-quarters full.
// Inputs and results each pass through a two-entry queue, so a new transfer
// is taken while a finished result still waits to be popped. Configuration
// writes take effect at once, so they should be made only while no transfer
// is in flight; a box count above MAX_BOXES acts as MAX_BOXES.
`default_nettype none

module box_window_correlator #(
	parameter int MAX_BOXES  = bwc_pkg::DEF_MAX_BOXES,
	parameter int RING_DEPTH = bwc_pkg::DEF_RING_DEPTH
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [bwc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire logic [bwc_pkg::DESC_BITS-1:0]       cfg_data,
	input  wire bwc_pkg::in_item_t                   item,
	input  wire logic                                push,
	output logic                                     full,
	output bwc_pkg::out_item_t                       result,
	output logic                                     empty,
	input  wire logic                                pop
);
	import bwc_pkg::*;

	logic [2:0]  num_boxes_q;
	desc_t       desc_q [MAX_BOXES];
	cmd_t        cmd;
	logic        cmd_empty;
	logic        cmd_pop;
	out_item_t   res;
	logic        res_push;
	logic        res_full;
	logic [$bits(out_item_t)-1:0] res_bits;

	// Configuration registers. Descriptors beyond MAX_BOXES are never used,
	// so writes to them are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_boxes_q <= '0;
			for (int k = 0; k < MAX_BOXES; k++) begin
				desc_q[k] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == CFG_NUM_BOXES) begin
				num_boxes_q <= cfg_data[2:0];
			end
			for (int k = 0; k < MAX_BOXES; k++) begin
				if (cfg_index == CFG_DESC_FIRST + CFG_INDEX_BITS'(k)) begin
					desc_q[k] <= desc_t'(cfg_data);
				end
			end
		end
	end

	// Front part: takes input transfers and queues them as commands.
	bwc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.push     (push),
		.full     (full),
		.cmd      (cmd),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop)
	);

	// Back part: carries out one command at a time.
	bwc_back #(
		.MAX_BOXES (MAX_BOXES),
		.RING_DEPTH(RING_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.num_boxes(num_boxes_q),
		.desc     (desc_q),
		.cmd      (cmd),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop),
		.res      (res),
		.res_push (res_push),
		.res_full (res_full)
	);

	// Result queue: decouples result delivery from the sequencer.
	bwc_queue #(.WIDTH($bits(out_item_t))) u_res_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.full  (res_full),
		.wdata (res),
		.pop   (pop),
		.empty (empty),
		.rdata (res_bits)
	);

	assign result = out_item_t'(res_bits);

`ifndef SYNTH
	// The sequencer only hands a result over when the result queue has room.
	a_no_lost_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && res_full |=> res_push)
		else $error("result dropped while the result queue was full");

	// A delivered result with an invalid score always carries a zero score.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !result.score_valid |-> result.score == '0)
		else $error("invalid result with a non-zero score");

	// A command is taken only while the sequencer is not producing a result.
	a_pop_excl_push: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd_pop && res_push))
		else $error("command taken while a result was being handed over");
`endif

endmodule

`default_nettype wire

@@ bench/box_window_correlator_tb.sv @@
// ----------------------------------------------------------------------------
// box_window_correlator_tb: self-checking bench of the box window correlator
// A queue-fed driver pushes feed and clear transfers, a clocked monitor pops
// results and checks each one against a score predictor kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module box_window_correlator_tb;

	import bwc_pkg::*;

	localparam int RING    = 1024;
	localparam int NBOX    = 6;
	localparam int DOG_MAX = 20000;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [DESC_BITS-1:0]      cfg_data;
	in_item_t                  item;
	logic                      push;
	logic                      full;
	out_item_t                 result;
	logic                      empty;
	logic                      pop;

	box_window_correlator dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .item(item), .push(push), .full(full),
		.result(result), .empty(empty), .pop(pop)
	);

	// Predictor state: a private copy of the ring, the boxes and the registers.
	logic [12:0]          ring_copy [RING];
	int unsigned          sum_copy  [NBOX];
	int unsigned          fill_copy [NBOX];
	int unsigned          seen_copy;
	int unsigned          wptr_copy;
	int unsigned          boxes_used;
	logic [DESC_BITS-1:0] desc_copy [NBOX];

	in_item_t  sample_q [$];
	out_item_t score_q  [$];
	int        failures;
	int        send_idle;
	int        recv_idle;
	int        dog = 0;
	int        n_results;
	int        n_valid;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint neg_mag(longint x);
		return (x > 0) ? -x : x;
	endfunction

	// Scores one transfer and advances the predictor state.
	function automatic out_item_t score_sample(in_item_t it);
		out_item_t   res;
		int unsigned newest, nb, age, w, v, idx;
		logic [12:0] e;
		desc_t       d;
		longint      tot, unc, f, f2, ex, ex2, th, wl;
		logic [31:0] acc;
		int          i;
		bit          qualified;
		res = '0;
		if (it.mode) begin
			// A clear empties every box but leaves the ring contents alone.
			for (int b = 0; b < NBOX; b++) begin
				sum_copy[b] = 0;
				fill_copy[b] = 0;
			end
			seen_copy = 0;
			wptr_copy = 0;
			return res;
		end
		newest = wptr_copy % RING;
		ring_copy[newest] = {it.sample_valid, it.sample};
		wptr_copy = (newest + 1) % RING;
		if (seen_copy < RING)
			seen_copy++;
		nb = (boxes_used > NBOX) ? NBOX : boxes_used;
		for (int b = 0; b < nb; b++) begin
			d = desc_copy[b];
			age = d.age;
			w = d.width;
			if (age < seen_copy) begin
				idx = (newest + RING - age) % RING;
				e = ring_copy[idx];
				v = e[11:0];
				if (e[12] && fill_copy[b] < 2 * RING - 1 && sum_copy[b] + v <= (1 << 22) - 1) begin
					sum_copy[b] += v;
					fill_copy[b]++;
				end
			end
			if (age + w < seen_copy) begin
				idx = (newest + RING - (age + w)) % RING;
				e = ring_copy[idx];
				v = e[11:0];
				if (e[12]) begin
					if (fill_copy[b] == 0) begin
						sum_copy[b] = 0;
					end else begin
						fill_copy[b]--;
						sum_copy[b] = (sum_copy[b] >= v) ? sum_copy[b] - v : 0;
					end
				end
			end
		end
		tot = 0;
		unc = 0;
		acc = '0;
		qualified = 1'b1;
		for (i = 0; i < nb; i++) begin
			d = desc_copy[i];
			wl = d.width;
			ex = d.expect1;
			ex2 = d.expect2;
			th = d.threshold;
			// Scoring stops at the first box at most three-quarters full.
			if (longint'(fill_copy[i]) < wl * 3 / 4 + 1) begin
				qualified = 1'b0;
				break;
			end
			f = sum_copy[i] / fill_copy[i];
			tot += wl;
			unc += wl - longint'(fill_copy[i]);
			if (d.btype == BT_BELOW) begin
				f = ex - f;
				if (f <= 0)
					f = 100;
				f += th;
			end else if (d.btype == BT_ABOVE) begin
				f -= ex;
				if (f <= 0)
					f = 100;
				f += th;
			end else if (d.btype == BT_SKIP) begin
				f = 0;
			end else if (d.btype == BT_BETWEEN && f > ex - th && f < ex2 + th) begin
				f = 100;
			end else if (d.btype == BT_BETWEEN || d.btype == BT_DUAL) begin
				f2 = neg_mag(f - ex2);
				f = neg_mag(f - ex);
				if (f2 > f)
					f = f2;
				f += th;
			end else begin
				f = neg_mag(f - ex) + th;
			end
			if (f < 0)
				f *= 4;
			acc += 32'(f * wl);
		end
		if (qualified && unc <= tot / 10) begin
			res.score = acc;
			res.score_valid = 1'b1;
		end
		return res;
	endfunction

	// Driver: the oldest pending transfer is offered until it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			item <= '0;
		end else begin
			if (push && !full) begin
				score_q.push_back(score_sample(item));
				void'(sample_q.pop_front());
			end
			if (push && full) begin
				// Held: item and push stay as they are.
			end else if (sample_q.size() > 0 && $urandom_range(99) >= send_idle) begin
				item <= sample_q[0];
				push <= 1'b1;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Monitor: each popped result is checked against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (score_q.size() == 0) begin
					$error("result transfer with no prediction waiting");
					failures++;
				end else begin
					if (result.score_valid !== score_q[0].score_valid) begin
						$error("score_valid: expected %0b, got %0b",
							score_q[0].score_valid, result.score_valid);
						failures++;
					end
					if (result.score !== score_q[0].score) begin
						$error("score: expected %0d, got %0d", score_q[0].score, result.score);
						failures++;
					end
					n_results++;
					if (score_q[0].score_valid)
						n_valid++;
					void'(score_q.pop_front());
				end
			end
			pop <= ($urandom_range(99) >= recv_idle);
		end
	end

	// Watchdog: counts cycles in which neither side completes a transfer.
	always @(posedge clk) begin
		if (arst_n && ((push && !full) || (pop && !empty))) begin
			dog <= 0;
		end else if (arst_n && (sample_q.size() > 0 || score_q.size() > 0)) begin
			dog <= dog + 1;
			if (dog >= DOG_MAX) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic write_reg(input int idx, input logic [DESC_BITS-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_INDEX_BITS'(idx);
		cfg_data <= val;
		if (idx == CFG_NUM_BOXES)
			boxes_used = val[2:0];
		else
			desc_copy[idx - CFG_DESC_FIRST] = val;
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		while (sample_q.size() > 0 || score_q.size() > 0 || push)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic in_item_t make_sample(int centre);
		in_item_t it;
		int r;
		it = '0;
		r = $urandom_range(99);
		if (r < 2) begin
			it.mode = 1'b1;
			it.sample = 12'($urandom);
			it.sample_valid = 1'($urandom);
		end else if (r < 7) begin
			it.sample = 12'($urandom);
			it.sample_valid = 1'($urandom);
		end else begin
			it.sample = 12'(centre + $urandom_range(240) - 120);
			it.sample_valid = 1'b1;
		end
		return it;
	endfunction

	function automatic desc_t make_desc(int centre);
		desc_t d;
		d.age = 10'($urandom_range(20));
		d.width = 10'($urandom_range(($urandom_range(3) == 0) ? 60 : 12, 1));
		d.btype = 3'($urandom_range(7));
		d.expect1 = 12'(centre + $urandom_range(200) - 100);
		d.expect2 = 12'(centre + $urandom_range(200) - 100);
		d.threshold = 12'($urandom_range(400) - 200);
		if ($urandom_range(7) == 0)
			d.threshold = 12'($urandom);
		return d;
	endfunction

	task automatic random_phase(input int n_items, input bit extreme);
		int centre;
		desc_t d;
		centre = $urandom_range(3900, 200);
		write_reg(CFG_NUM_BOXES, DESC_BITS'(extreme ? 7 : $urandom_range(6)));
		for (int b = 0; b < NBOX; b++) begin
			d = make_desc(centre);
			write_reg(CFG_DESC_FIRST + b, extreme ? DESC_BITS'({$urandom, $urandom}) : d);
		end
		end_writes();
		for (int k = 0; k < n_items; k++)
			sample_q.push_back(make_sample(centre));
		wait_drained();
	endtask

	initial begin
		desc_t    d;
		in_item_t it;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		failures = 0;
		n_results = 0;
		n_valid = 0;
		send_idle = 15;
		recv_idle = 52;
		for (int k = 0; k < RING; k++)
			ring_copy[k] = '0;
		for (int b = 0; b < NBOX; b++) begin
			sum_copy[b] = 0;
			fill_copy[b] = 0;
			desc_copy[b] = '0;
		end
		seen_copy = 0;
		wptr_copy = 0;
		boxes_used = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: no boxes in use, extreme samples, invalid samples and clears.
		it = '0;
		it.mode = 1'b1;
		sample_q.push_back(it);
		it = '0;
		it.sample_valid = 1'b1;
		sample_q.push_back(it);
		it.sample = 12'hFFF;
		sample_q.push_back(it);
		it.sample_valid = 1'b0;
		sample_q.push_back(it);
		wait_drained();

		// Directed: one box of every type over short windows, fed rising samples.
		write_reg(CFG_NUM_BOXES, DESC_BITS'(6));
		for (int b = 0; b < NBOX; b++) begin
			d.age = 10'(b);
			d.width = 10'(b + 1);
			d.btype = 3'(b);
			d.expect1 = 12'd1000;
			d.expect2 = 12'd1100;
			d.threshold = (b == 4) ? 12'sd80 : -12'sd20;
			write_reg(CFG_DESC_FIRST + b, d);
		end
		end_writes();
		for (int k = 0; k < 16; k++) begin
			it = '0;
			it.sample = 12'(1000 + 13 * k);
			it.sample_valid = (k != 9);
			sample_q.push_back(it);
		end
		// The sender holds off here until every result has come back.
		wait_drained();
		it = '0;
		it.mode = 1'b1;
		sample_q.push_back(it);
		wait_drained();

		// Random phases: the idling pattern changes a third and two thirds in.
		for (int p = 0; p < 9; p++) begin
			if (p == 3) begin
				send_idle = 52;
				recv_idle = 15;
			end else if (p == 6) begin
				send_idle = 0;
				recv_idle = 0;
			end
			random_phase((p == 4) ? 20 : 50, p == 4);
		end
		write_reg(CFG_NUM_BOXES, DESC_BITS'(0));
		end_writes();
		random_phase(10, 1'b0);

		repeat (200) @(posedge clk);
		$display("Covered %0d result transfers, %0d with a valid score, over ten settings",
			n_results, n_valid);
		if (failures == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
